// ===== hdl/a2t_pkg.sv =====
// a2t_pkg: shared types, codes and small index helpers for the affine 2d transform unit
// no dependencies; imported by every module of the block
`default_nettype none

package a2t_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ENTRIES   = 9;

  // operation codes carried in a request
  typedef enum logic [3:0] {
    FN_IDENTITY     = 4'd0,
    FN_ROTATE       = 4'd1,
    FN_TRANSLATE    = 4'd2,
    FN_SCALE        = 4'd3,
    FN_SHEAR_X      = 4'd4,
    FN_SHEAR_Y      = 4'd5,
    FN_MUL_FACTOR   = 4'd6,
    FN_DIV_FACTOR   = 4'd7,
    FN_XFORM_VECTOR = 4'd8,
    FN_XFORM_POINT  = 4'd9
  } func_t;

  typedef logic [3:0] idx_t;
  typedef logic [1:0] term_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] a_value;
    logic signed [31:0] b_value;
    logic signed [31:0] c_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               was_divided;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAC,
    ST_DRAIN,
    ST_VCHK,
    ST_DIV,
    ST_DIVW,
    ST_COMMIT,
    ST_OUT
  } st_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  mac;
    logic  first;
    logic  last;
    idx_t  idx;
    term_t term;
    logic  div_start;
    logic  commit;
    logic  out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  a_zero;
    logic  need_div;
    logic  div_done;
    logic  out_free;
  } dp_stat_t;

  // row of a row-major 3x3 entry index
  function automatic term_t row_of(idx_t i);
    term_t r;
    unique case (i)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // column of a row-major 3x3 entry index
  function automatic term_t col_of(idx_t i);
    term_t c;
    unique case (i)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // first entry index of a row
  function automatic idx_t mul3(term_t t);
    return idx_t'({2'b00, t}) + idx_t'({1'b0, t, 1'b0});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/a2t_div.sv =====
// a2t_div: restoring divider, one quotient bit a cycle, computes sat(num * 2^F / den)
// depends on a2t_pkg
`default_nettype none

module a2t_div import a2t_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      q,
  output logic                    sat
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] dvd_r, quo_r;
  logic [31:0]      rem_r, dmag_r;
  logic             neg_r;
  logic [31:0]      nmag, dmag;
  logic [32:0]      rem_sh;
  logic             ge;
  logic             ovf;

  // operand magnitudes
  assign nmag   = num[31] ? 32'(-num) : 32'(num);
  assign dmag   = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh = {rem_r, dvd_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag_r};

  // control flags
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= {nmag, {FRAC_BITS{1'b0}}};
      quo_r  <= '0;
      rem_r  <= '0;
      dmag_r <= dmag;
      neg_r  <= num[31] ^ den[31];
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // sign and saturate
  always_comb begin
    if (neg_r) begin
      ovf = (|quo_r[NUM_W-1:32]) || (quo_r[31] && (|quo_r[30:0]));
      q   = ovf ? 32'sh8000_0000 : 32'(-quo_r[31:0]);
    end else begin
      ovf = |quo_r[NUM_W-1:31];
      q   = ovf ? 32'sh7fff_ffff : 32'(quo_r[31:0]);
    end
  end

  assign sat  = ovf;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== hdl/a2t_datapath.sv =====
// a2t_datapath: matrix store, shared multiply-accumulate, divider and result register
// depends on a2t_pkg and a2t_div
`default_nettype none

module a2t_datapath import a2t_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire ctrl_cmd_t cmd,
  output dp_stat_t       stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int PROD_W = 65;
  localparam int ACC_W  = 67;
  localparam logic signed [31:0] ONE_Q = 32'sd1 << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] MAXV = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  // elementary matrix entry, 33 bits so that the negated sine fits
  function automatic logic signed [32:0] e_entry(func_t f, logic signed [31:0] a,
                                                 logic signed [31:0] b, idx_t i);
    logic signed [32:0] one_e, av, bv, r;
    one_e = 33'(ONE_Q);
    av    = 33'(a);
    bv    = 33'(b);
    r     = (i == 4'd0 || i == 4'd4 || i == 4'd8) ? one_e : 33'sd0;
    case (f)
      FN_ROTATE: begin
        if (i == 4'd0 || i == 4'd4) r = bv;
        if (i == 4'd1) r = -av;
        if (i == 4'd3) r = av;
      end
      FN_TRANSLATE: begin
        if (i == 4'd2) r = av;
        if (i == 4'd5) r = bv;
      end
      FN_SCALE: begin
        if (i == 4'd0) r = av;
        if (i == 4'd4) r = bv;
      end
      FN_SHEAR_X: if (i == 4'd1) r = av;
      FN_SHEAR_Y: if (i == 4'd3) r = av;
      default: ;
    endcase
    return r;
  endfunction

  logic signed [31:0]       m_r [NUM_ENTRIES];
  logic signed [31:0]       new_r [NUM_ENTRIES];
  func_t                    func_r;
  logic signed [31:0]       a_r, b_r, c_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     mac_d_r, first_d_r, last_d_r;
  idx_t                     idx_d_r;
  logic                     sat_r;
  out_item_t                out_r;
  logic                     out_valid_r, out_valid_nxt;

  logic                     is_compose, is_xform, is_vector;
  term_t                    row, col;
  idx_t                     maddr, eaddr;
  logic signed [31:0]       mval, vec_val, opb;
  logic signed [32:0]       e_val, opa;
  logic signed [ACC_W-1:0]  sum, rnd;
  logic signed [31:0]       satv;
  logic                     clip;
  logic                     need_div;
  logic signed [31:0]       div_num, div_den, div_q;
  logic                     div_done, div_sat;

  assign is_compose = func_r >= FN_ROTATE && func_r <= FN_SHEAR_Y;
  assign is_vector  = func_r == FN_XFORM_VECTOR;
  assign is_xform   = is_vector || func_r == FN_XFORM_POINT;
  assign row        = row_of(cmd.idx);
  assign col        = col_of(cmd.idx);

  // single read address into the stored matrix
  always_comb begin
    if (is_compose) begin
      maddr = mul3(cmd.term) + idx_t'(col);
    end else if (is_xform) begin
      maddr = mul3(cmd.idx[1:0]) + idx_t'(cmd.term);
    end else begin
      maddr = cmd.idx;
    end
  end

  assign mval  = m_r[maddr];
  assign eaddr = mul3(row) + idx_t'(cmd.term);
  assign e_val = e_entry(func_r, a_r, b_r, eaddr);

  // vector operand for transforms
  always_comb begin
    case (cmd.term)
      2'd0:    vec_val = a_r;
      2'd1:    vec_val = b_r;
      default: vec_val = is_vector ? ONE_Q : c_r;
    endcase
  end

  // multiplier operands
  always_comb begin
    if (is_compose) begin
      opa = e_val;
      opb = mval;
    end else if (is_xform) begin
      opa = 33'(mval);
      opb = vec_val;
    end else begin
      opa = 33'(mval);
      opb = a_r;
    end
  end

  // accumulate, round half up, saturate
  assign sum  = (first_d_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
  assign rnd  = (sum + HALF) >>> FRAC_BITS;
  assign clip = rnd > MAXV || rnd < MINV;
  assign satv = (rnd > MAXV) ? 32'sh7fff_ffff :
                (rnd < MINV) ? 32'sh8000_0000 : 32'(rnd);

  assign need_div = new_r[2] != 32'sd0 && new_r[2] != ONE_Q;

  // divider operands
  assign div_num = is_vector ? new_r[cmd.idx] : mval;
  assign div_den = is_vector ? new_r[2] : a_r;

  a2t_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q),
    .sat   (div_sat)
  );

  // request capture and operand pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      a_r    <= in_data.a_value;
      b_r    <= in_data.b_value;
      c_r    <= in_data.c_value;
    end
    prod_r    <= opa * opb;
    first_d_r <= cmd.first;
    last_d_r  <= cmd.last;
    idx_d_r   <= cmd.idx;
    if (mac_d_r) acc_r <= sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_d_r <= 1'b0;
    end else begin
      mac_d_r <= cmd.mac;
    end
  end

  // stored matrix, reset and identity request give the identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        m_r[i] <= (i % 4 == 0) ? ONE_Q : 32'sd0;
      end
    end else if (cmd.load && in_data.func == FN_IDENTITY) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        m_r[i] <= (i % 4 == 0) ? ONE_Q : 32'sd0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        m_r[i] <= new_r[i];
      end
    end
  end

  // working entries and clip flag
  always_ff @(posedge clk) begin
    if (mac_d_r && last_d_r) new_r[idx_d_r] <= satv;
    if (div_done) new_r[cmd.idx] <= div_q;
    if (cmd.load) begin
      sat_r <= 1'b0;
    end else if ((mac_d_r && last_d_r && clip) || (div_done && div_sat)) begin
      sat_r <= 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.out_x       <= new_r[0];
      out_r.out_y       <= new_r[1];
      out_r.out_z       <= new_r[2];
      out_r.was_divided <= is_vector && need_div;
      out_r.saturated   <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.func     = func_r;
  assign stat.a_zero   = a_r == 32'sd0;
  assign stat.need_div = need_div;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== hdl/a2t_ctrl.sv =====
// a2t_ctrl: sequencer that walks entries and terms and drives the datapath
// depends on a2t_pkg
`default_nettype none

module a2t_ctrl import a2t_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd
);

  st_t   state_r, state_nxt;
  idx_t  idx_r, idx_nxt;
  term_t term_r, term_nxt;
  logic  is_compose, is_vector, is_xform;
  idx_t  idx_max, div_last;
  term_t term_max;
  logic  last_term, mac_end;

  assign is_compose = stat.func >= FN_ROTATE && stat.func <= FN_SHEAR_Y;
  assign is_vector  = stat.func == FN_XFORM_VECTOR;
  assign is_xform   = is_vector || stat.func == FN_XFORM_POINT;
  assign idx_max    = is_xform ? 4'd2 : 4'd8;
  assign div_last   = is_vector ? 4'd1 : 4'd8;
  assign term_max   = stat.func == FN_MUL_FACTOR ? 2'd0 : 2'd2;
  assign last_term  = term_r == term_max;
  assign mac_end    = last_term && idx_r == idx_max;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (is_compose || is_xform || stat.func == FN_MUL_FACTOR) begin
          state_nxt = ST_MAC;
        end else if (stat.func == FN_DIV_FACTOR && !stat.a_zero) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MAC: if (mac_end) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (is_vector) begin
          state_nxt = ST_VCHK;
        end else if (is_xform) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_VCHK:   state_nxt = stat.need_div ? ST_DIV : ST_OUT;
      ST_DIV:    state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (stat.div_done) begin
          if (idx_r != div_last) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = is_vector ? ST_OUT : ST_COMMIT;
          end
        end
      end
      ST_COMMIT: state_nxt = ST_IDLE;
      ST_OUT:    if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // entry and term counters
  always_comb begin
    idx_nxt  = idx_r;
    term_nxt = term_r;
    if (state_r == ST_DECODE || state_r == ST_VCHK) begin
      idx_nxt  = '0;
      term_nxt = '0;
    end else if (state_r == ST_MAC) begin
      if (last_term) begin
        term_nxt = '0;
        idx_nxt  = idx_r + 4'd1;
      end else begin
        term_nxt = term_r + 2'd1;
      end
    end else if (state_r == ST_DIVW && stat.div_done) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      term_r  <= term_nxt;
    end
  end

  // commands
  always_comb begin
    in_ready      = state_r == ST_IDLE;
    cmd.load      = state_r == ST_IDLE && in_valid;
    cmd.mac       = state_r == ST_MAC;
    cmd.first     = term_r == 2'd0;
    cmd.last      = last_term;
    cmd.idx       = idx_r;
    cmd.term      = term_r;
    cmd.div_start = state_r == ST_DIV;
    cmd.commit    = state_r == ST_COMMIT;
    cmd.out_load  = state_r == ST_OUT && stat.out_free;
  end

endmodule

`default_nettype wire

// ===== hdl/affine_2d_transform_unit.sv =====
// affine_2d_transform_unit: top level, joins the sequencer and the datapath
// depends on a2t_pkg, a2t_ctrl, a2t_datapath
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_data  (in_item_t)
//   out      out_valid / out_ready out_data (out_item_t)
//
// one request at a time, through a single 33x32 multiplier and a radix-2 divider
// matrix updates: three products summed per entry, then commit; scale by factor: one per entry
// point transform: three sums plus result handoff; vector: x, y divided by w unless w is 0 or 1
// divide by factor: nine divides, one quotient bit a cycle; zero factor: no-op; identity: reload
// synchronous reset loads the identity matrix; a stalled result holds in its register
`default_nettype none

module affine_2d_transform_unit import a2t_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  a2t_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  a2t_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/a2t_checker.sv =====
// a2t_port_checks: port-level assertions for the transform unit, bound to the top level
// depends on a2t_pkg and affine_2d_transform_unit
`default_nettype none

module a2t_port_checks import a2t_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  localparam logic signed [31:0] ONE_Q = 32'sd1 << FRAC_BITS;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: no request taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a divide only happens for w other than zero and one
  a_divide_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_divided |->
      out_data.out_z != 32'sd0 && out_data.out_z != ONE_Q)
    else $error("divided with w of zero or one");

endmodule

bind affine_2d_transform_unit a2t_port_checks #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);

`default_nettype wire
